// ===== hdl/u16u8_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the UTF-16LE to UTF-8 transcoder.
// Depends on nothing; every other file of the block but u16u8_ifs uses it.
package u16u8_pkg;

    localparam logic [15:0] MAX_BYTES_RESET = 16'd255;
    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam int          MAX_SEQ_BYTES   = 6;

    localparam logic [5:0]  HIGH_SURR_TAG   = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG    = 6'b110111;

    localparam logic [7:0]  LEAD_2          = 8'hC0;
    localparam logic [7:0]  LEAD_3          = 8'hE0;
    localparam logic [7:0]  LEAD_4          = 8'hF0;
    localparam logic [7:0]  CONT_MARK       = 8'h80;

    typedef logic [2:0][7:0] bytes3_t;

    typedef struct packed {
        logic [MAX_SEQ_BYTES-1:0][7:0] data;
        logic [2:0]                    nbytes;
        logic                          end_rec;
        logic [15:0]                   count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hdl/u16u8_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the transcoder: code units in, results out, register writes.
// Depends on nothing.
interface u16u8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;
    modport source (output valid, code_unit, last_unit, input ready);
    modport sink   (input valid, code_unit, last_unit, output ready);
endinterface

interface u16u8_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        end_record;
    logic [15:0] byte_count;
    logic        last_of_item;
    modport source (output valid, out_byte, end_record, byte_count, last_of_item, input ready);
    modport sink   (input valid, out_byte, end_record, byte_count, last_of_item, output ready);
endinterface

interface u16u8_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_bytes;
    modport source (output valid, max_bytes, input ready);
    modport sink   (input valid, max_bytes, output ready);
endinterface

// ===== hdl/utf16le_to_utf8_transcoder.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-16LE to UTF-8 transcoder: capacity register, front end, queue, back end.
// Depends on u16u8_pkg, u16u8_ifs, u16u8_front, u16u8_queue and u16u8_back.

// A code unit word is taken in every cycle while the internal queue has room; it is turned into
// at most one entry in that cycle and the back end sends the entry's results at one result word
// per cycle while results.ready is high. A word gives as many result words as its entry holds:
// one to three for a character of the basic plane, four for a surrogate pair, up to seven when a
// held high surrogate is flushed together with the next character and an end record.
// Sustained throughput is one result word per cycle while results.ready is high, set by the
// output side. The first result of a word is registered in a queue slot and then in the back
// end's current entry before it is presented. Writes to max_bytes are always accepted.
module utf16le_to_utf8_transcoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    u16u8_unit_if.sink     units,
    u16u8_result_if.source results,
    u16u8_cfg_if.sink      cfg
);

    logic [15:0]          max_bytes_reg;
    logic                 push, pop;
    u16u8_pkg::entry_t    wr_entry, head;
    u16u8_pkg::q_status_t q_stat;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_bytes_reg <= u16u8_pkg::MAX_BYTES_RESET;
        end else if (cfg.valid && cfg.ready) begin
            max_bytes_reg <= cfg.max_bytes;
        end
    end

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .units     (units),
        .max_bytes (max_bytes_reg),
        .q_stat    (q_stat),
        .push      (push),
        .entry     (wr_entry)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .stat     (q_stat)
    );

    u16u8_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .head    (head),
        .pop     (pop),
        .results (results)
    );

endmodule

// ===== hdl/u16u8_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts code units, pairs surrogates, checks capacity and builds at most one queue entry per unit.
// Depends on u16u8_pkg and u16u8_ifs.
module u16u8_front (
    input  logic                 clk,
    input  logic                 rst_n,
    u16u8_unit_if.sink           units,
    input  logic [15:0]          max_bytes,
    input  u16u8_pkg::q_status_t q_stat,
    output logic                 push,
    output u16u8_pkg::entry_t    entry
);

    function automatic u16u8_pkg::bytes3_t enc_bmp(input logic [15:0] cp);
        u16u8_pkg::bytes3_t b;
        b = '0;
        if (cp[15:7] == 9'd0) begin
            b[0] = cp[7:0];
        end else if (cp[15:11] == 5'd0) begin
            b[0] = u16u8_pkg::LEAD_2 | {3'b000, cp[10:6]};
            b[1] = u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
        end else begin
            b[0] = u16u8_pkg::LEAD_3 | {4'b0000, cp[15:12]};
            b[1] = u16u8_pkg::CONT_MARK | {2'b00, cp[11:6]};
            b[2] = u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]};
        end
        return b;
    endfunction

    logic [15:0] pend_hi_reg, pend_hi_next;
    logic        pend_v_reg, pend_v_next;
    logic [15:0] wc_reg, wc_next;
    logic        stop_reg, stop_next;

    logic        accept;
    logic [15:0] u;
    logic        is_hi_u, is_lo_u;
    logic [1:0]  len_u;
    logic [16:0] wc_p3, wc_p4, wc_base, wc_u;
    logic        fit3, fit4, fit_u, after_hi;
    logic [20:0] sur_cp;
    u16u8_pkg::bytes3_t hi_bytes, u_bytes;

    assign u        = units.code_unit;
    assign accept   = units.valid && units.ready;
    assign units.ready = !q_stat.full;

    assign is_hi_u  = (u[15:10] == u16u8_pkg::HIGH_SURR_TAG);
    assign is_lo_u  = (u[15:10] == u16u8_pkg::LOW_SURR_TAG);
    assign len_u    = (u[15:7] == 9'd0) ? 2'd1 : ((u[15:11] == 5'd0) ? 2'd2 : 2'd3);

    assign wc_p3    = {1'b0, wc_reg} + 17'd3;
    assign wc_p4    = {1'b0, wc_reg} + 17'd4;
    assign fit3     = (wc_p3 <= {1'b0, max_bytes});
    assign fit4     = (wc_p4 <= {1'b0, max_bytes});
    assign after_hi = !stop_reg && pend_v_reg && !is_lo_u && fit3;
    assign wc_base  = after_hi ? wc_p3 : {1'b0, wc_reg};
    assign wc_u     = wc_base + {15'd0, len_u};
    assign fit_u    = (wc_u <= {1'b0, max_bytes});

    assign sur_cp   = {1'b0, pend_hi_reg[9:0], u[9:0]} + 21'h10000;
    assign hi_bytes = enc_bmp(pend_hi_reg);
    assign u_bytes  = enc_bmp(u);

    always_comb
    begin
        logic do_unit;
        pend_hi_next = pend_hi_reg;
        pend_v_next  = pend_v_reg;
        wc_next      = wc_reg;
        stop_next    = stop_reg;
        entry        = '0;
        do_unit      = 1'b0;
        if (!stop_reg) begin
            if (pend_v_reg) begin
                pend_v_next = 1'b0;
                if (is_lo_u) begin
                    if (fit4) begin
                        entry.data[0] = u16u8_pkg::LEAD_4 | {5'd0, sur_cp[20:18]};
                        entry.data[1] = u16u8_pkg::CONT_MARK | {2'b00, sur_cp[17:12]};
                        entry.data[2] = u16u8_pkg::CONT_MARK | {2'b00, sur_cp[11:6]};
                        entry.data[3] = u16u8_pkg::CONT_MARK | {2'b00, sur_cp[5:0]};
                        entry.nbytes  = 3'd4;
                        wc_next       = wc_p4[15:0];
                    end else begin
                        stop_next = 1'b1;
                    end
                end else if (fit3) begin
                    entry.data[0] = hi_bytes[0];
                    entry.data[1] = hi_bytes[1];
                    entry.data[2] = hi_bytes[2];
                    entry.nbytes  = 3'd3;
                    wc_next       = wc_p3[15:0];
                    do_unit       = 1'b1;
                end else begin
                    stop_next = 1'b1;
                end
            end else begin
                do_unit = 1'b1;
            end
        end
        if (do_unit) begin
            if (u == 16'd0) begin
                stop_next   = 1'b1;
                pend_v_next = 1'b0;
            end else if (is_hi_u && !units.last_unit) begin
                pend_hi_next = u;
                pend_v_next  = 1'b1;
            end else if (fit_u) begin
                if (after_hi) begin
                    entry.data[3] = u_bytes[0];
                    entry.data[4] = u_bytes[1];
                    entry.data[5] = u_bytes[2];
                end else begin
                    entry.data[0] = u_bytes[0];
                    entry.data[1] = u_bytes[1];
                    entry.data[2] = u_bytes[2];
                end
                entry.nbytes = entry.nbytes + {1'b0, len_u};
                wc_next      = wc_u[15:0];
            end else begin
                stop_next   = 1'b1;
                pend_v_next = 1'b0;
            end
        end
        if (units.last_unit) begin
            entry.end_rec = 1'b1;
            entry.count   = wc_next;
            pend_hi_next  = '0;
            pend_v_next   = 1'b0;
            wc_next       = '0;
            stop_next     = 1'b0;
        end
    end

    assign push = accept && ((entry.nbytes != 3'd0) || entry.end_rec);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_hi_reg <= '0;
            pend_v_reg  <= 1'b0;
            wc_reg      <= '0;
            stop_reg    <= 1'b0;
        end else if (accept) begin
            pend_hi_reg <= pend_hi_next;
            pend_v_reg  <= pend_v_next;
            wc_reg      <= wc_next;
            stop_reg    <= stop_next;
        end
    end

    // A held unit is always a high surrogate.
    a_pend_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        pend_v_reg |-> (pend_hi_reg[15:10] == u16u8_pkg::HIGH_SURR_TAG))
        else $error("held unit is not a high surrogate");

    a_stop_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> !pend_v_reg)
        else $error("unit held after conversion stopped");

    // The final word of a string clears all string state.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && units.last_unit) |=> (wc_reg == 16'd0 && !stop_reg && !pend_v_reg))
        else $error("string state not cleared after last word");

endmodule

// ===== hdl/u16u8_queue.sv =====
`timescale 1ns / 1ps
// Small first-in first-out queue of entries between the front and back ends.
// Depends on u16u8_pkg.
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  u16u8_pkg::entry_t    wr_entry,
    input  logic                 pop,
    output u16u8_pkg::entry_t    rd_entry,
    output u16u8_pkg::q_status_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign rd_entry   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== hdl/u16u8_back.sv =====
`timescale 1ns / 1ps
// Back end: takes entries from the queue and sends their results one word per cycle while results.ready is high.
// Depends on u16u8_pkg and u16u8_ifs.
module u16u8_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u16u8_pkg::q_status_t q_stat,
    input  u16u8_pkg::entry_t    head,
    output logic                 pop,
    u16u8_result_if.source       results
);

    u16u8_pkg::entry_t cur_reg, cur_next;
    logic              cur_v_reg, cur_v_next;
    logic [2:0]        idx_reg, idx_next;

    logic [2:0] total;
    logic       fire, last_res;

    assign total    = cur_reg.nbytes + {2'b00, cur_reg.end_rec};
    assign fire     = results.valid && results.ready;
    assign last_res = (idx_reg == total - 3'd1);
    assign pop      = !q_stat.empty && (!cur_v_reg || (fire && last_res));

    always_comb
    begin
        results.valid        = cur_v_reg;
        results.out_byte     = '0;
        results.end_record   = 1'b0;
        results.byte_count   = '0;
        results.last_of_item = last_res;
        if (idx_reg < cur_reg.nbytes) begin
            results.out_byte = cur_reg.data[idx_reg];
        end else begin
            results.end_record = 1'b1;
            results.byte_count = cur_reg.count;
        end
    end

    always_comb
    begin
        cur_next   = cur_reg;
        cur_v_next = cur_v_reg;
        idx_next   = idx_reg;
        if (fire) begin
            idx_next = idx_reg + 3'd1;
            if (last_res) begin
                cur_v_next = 1'b0;
                idx_next   = '0;
            end
        end
        if (pop) begin
            cur_next   = head;
            cur_v_next = 1'b1;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_v_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            cur_v_reg <= cur_v_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_v_reg |-> (idx_reg < total))
        else $error("result index past end of entry");

    // The end record closes the results of its word.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.end_record) |-> results.last_of_item)
        else $error("end record not marked last");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("entry taken from empty queue");

endmodule

// ===== test/utf16le_to_utf8_transcoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of utf16le_to_utf8_transcoder: directed table, then random strings.
// Depends on u16u8_pkg, the channel interfaces in u16u8_ifs and the transcoder itself.
module utf16le_to_utf8_transcoder_tb;

    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int LONG_HOLD     = 80;
    localparam int PHASE_UNITS   = 16;
    localparam int NUM_PHASES    = 8;
    localparam int DIR_ROWS      = 28;

    typedef enum logic {ROW_UNIT, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [15:0]      value;
        logic             fin;
        logic [2:0]       n_typed;
        logic [0:3][24:0] typed;
    } stim_row_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        end_record;
        logic [15:0] byte_count;
        logic        last_of_item;
    } utf8_word_t;

    localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{ROW_UNIT, 16'h0000, 1'b1, 3'd1, {8'h00, 1'b1, 16'd0, 75'd0}},
        '{ROW_UNIT, 16'h0041, 1'b0, 3'd1, {8'h41, 1'b0, 16'd0, 75'd0}},
        '{ROW_UNIT, 16'h007F, 1'b0, 3'd1, {8'h7F, 1'b0, 16'd0, 75'd0}},
        '{ROW_UNIT, 16'h0080, 1'b0, 3'd2, {8'hC2, 1'b0, 16'd0, 8'h80, 1'b0, 16'd0, 50'd0}},
        '{ROW_UNIT, 16'h07FF, 1'b0, 3'd2, {8'hDF, 1'b0, 16'd0, 8'hBF, 1'b0, 16'd0, 50'd0}},
        '{ROW_UNIT, 16'h0800, 1'b0, 3'd3, {8'hE0, 1'b0, 16'd0, 8'hA0, 1'b0, 16'd0,
                                          8'h80, 1'b0, 16'd0, 25'd0}},
        '{ROW_UNIT, 16'hFFFF, 1'b1, 3'd4, {8'hEF, 1'b0, 16'd0, 8'hBF, 1'b0, 16'd0,
                                          8'hBF, 1'b0, 16'd0, 8'h00, 1'b1, 16'd12}},
        '{ROW_UNIT, 16'hD800, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hDC00, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hDBFF, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hDFFF, 1'b1, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hDC00, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hD83D, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h0041, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hD800, 1'b1, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hDBFF, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hD801, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h20AC, 1'b1, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h0042, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h0000, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h0043, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h0044, 1'b1, 3'd1, {8'h00, 1'b1, 16'd1, 75'd0}},
        '{ROW_CAP,  16'd0,    1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h0041, 1'b1, 3'd1, {8'h00, 1'b1, 16'd0, 75'd0}},
        '{ROW_CAP,  16'd4,    1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h20AC, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'h00E9, 1'b0, 3'd0, 100'd0},
        '{ROW_UNIT, 16'hD800, 1'b1, 3'd1, {8'h00, 1'b1, 16'd3, 75'd0}}
    };

    localparam logic [15:0] PHASE_CAPS [0:NUM_PHASES-1] = '{
        16'd1, 16'd3, 16'd255, 16'd5, 16'd2, 16'hFFFF, 16'd0, 16'd12
    };

    logic clk = 1'b0;
    logic rst_n;

    u16u8_unit_if   unit_ch ();
    u16u8_result_if res_ch ();
    u16u8_cfg_if    cap_ch ();

    utf16le_to_utf8_transcoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .units   (unit_ch),
        .results (res_ch),
        .cfg     (cap_ch)
    );

    always #4 clk = ~clk;

    logic [15:0] cap_bytes;
    logic [15:0] held_high;
    logic        held_valid;
    logic [15:0] byte_total;
    logic        halted;

    logic [7:0] item_bytes [$];
    utf8_word_t item_words [$];
    utf8_word_t pending_words [$];

    int  mismatches;
    int  units_sent;
    int  result_words;
    int  end_records;
    int  cap_writes;
    bit  calm;
    bit  hold_request;

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 100)
        begin
            $display("MISMATCH at %0t ns: %s", $time, msg);
        end
    endtask

    function automatic bit is_high_surr(input logic [15:0] u);
        return u[15:10] == u16u8_pkg::HIGH_SURR_TAG;
    endfunction

    function automatic bit is_low_surr(input logic [15:0] u);
        return u[15:10] == u16u8_pkg::LOW_SURR_TAG;
    endfunction

    function void encode_code_point(input int cp);
        int len;
        len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
        if (int'(byte_total) + len > int'(cap_bytes))
        begin
            halted = 1'b1;
            held_valid = 1'b0;
        end
        else
        begin
            case (len)
                1:
                begin
                    item_bytes.push_back(cp[7:0]);
                end
                2:
                begin
                    item_bytes.push_back(u16u8_pkg::LEAD_2 | {3'b000, cp[10:6]});
                    item_bytes.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]});
                end
                3:
                begin
                    item_bytes.push_back(u16u8_pkg::LEAD_3 | {4'b0000, cp[15:12]});
                    item_bytes.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[11:6]});
                    item_bytes.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]});
                end
                default:
                begin
                    item_bytes.push_back(u16u8_pkg::LEAD_4 | {5'b00000, cp[20:18]});
                    item_bytes.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[17:12]});
                    item_bytes.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[11:6]});
                    item_bytes.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]});
                end
            endcase
            byte_total = byte_total + 16'(len);
        end
    endfunction

    function void take_unit(input logic [15:0] u, input logic fin);
        if (u == 16'h0000)
        begin
            halted = 1'b1;
            held_valid = 1'b0;
        end
        else if (is_high_surr(u) && !fin)
        begin
            held_high = u;
            held_valid = 1'b1;
        end
        else
        begin
            encode_code_point(int'(u));
        end
    endfunction

    function void transcode_unit(input logic [15:0] u, input logic fin);
        int k;
        item_bytes.delete();
        item_words.delete();
        if (!halted)
        begin
            if (held_valid)
            begin
                held_valid = 1'b0;
                if (is_low_surr(u))
                begin
                    encode_code_point('h10000 + (int'(held_high[9:0]) << 10) + int'(u[9:0]));
                end
                else
                begin
                    encode_code_point(int'(held_high));
                    if (!halted)
                    begin
                        take_unit(u, fin);
                    end
                end
            end
            else
            begin
                take_unit(u, fin);
            end
        end
        for (k = 0; k < item_bytes.size(); k++)
        begin
            item_words.push_back('{item_bytes[k], 1'b0, 16'd0, 1'b0});
        end
        if (fin)
        begin
            item_words.push_back('{8'h00, 1'b1, byte_total, 1'b0});
            held_high = 16'd0;
            held_valid = 1'b0;
            byte_total = 16'd0;
            halted = 1'b0;
        end
        if (item_words.size() > 0)
        begin
            item_words[item_words.size() - 1].last_of_item = 1'b1;
        end
    endfunction

    task automatic send_unit(input logic [15:0] u, input logic fin, input int n_typed,
                             input logic [0:3][24:0] typed);
        int k;
        utf8_word_t w;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            unit_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        unit_ch.valid     <= 1'b1;
        unit_ch.code_unit <= u;
        unit_ch.last_unit <= fin;
        @(posedge clk);
        while (!unit_ch.ready)
        begin
            @(posedge clk);
        end
        transcode_unit(u, fin);
        units_sent++;
        if (n_typed == 0)
        begin
            for (k = 0; k < item_words.size(); k++)
            begin
                pending_words.push_back(item_words[k]);
            end
        end
        else
        begin
            for (k = 0; k < n_typed; k++)
            begin
                w = {typed[k], k == n_typed - 1};
                pending_words.push_back(w);
            end
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        unit_ch.valid <= 1'b0;
        while (pending_words.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        wait_drained();
        cap_ch.valid     <= 1'b1;
        cap_ch.max_bytes <= v;
        @(posedge clk);
        while (!cap_ch.ready)
        begin
            @(posedge clk);
        end
        cap_bytes = v;
        cap_writes++;
        @(negedge clk);
        cap_ch.valid <= 1'b0;
    endtask

    task automatic send_random_char();
        int sel;
        logic fin;
        logic [15:0] u;
        sel = $urandom_range(0, 99);
        fin = ($urandom_range(0, 5) == 0);
        if (sel < 22)
        begin
            u = 16'($urandom_range(1, 'h7F));
        end
        else if (sel < 38)
        begin
            u = 16'($urandom_range('h80, 'h7FF));
        end
        else if (sel < 54)
        begin
            u = ($urandom_range(0, 1) == 0) ? 16'($urandom_range('h800, 'hD7FF))
                                            : 16'($urandom_range('hE000, 'hFFFF));
        end
        else if (sel < 74)
        begin
            send_unit(16'($urandom_range('hD800, 'hDBFF)), 1'b0, 0, '0);
            u = 16'($urandom_range('hDC00, 'hDFFF));
        end
        else if (sel < 80)
        begin
            u = 16'($urandom_range('hD800, 'hDBFF));
        end
        else if (sel < 86)
        begin
            u = 16'($urandom_range('hDC00, 'hDFFF));
        end
        else if (sel < 90)
        begin
            u = 16'h0000;
        end
        else
        begin
            u = 16'($urandom);
        end
        send_unit(u, fin, 0, '0);
    endtask

    task automatic check_result_word();
        utf8_word_t got;
        utf8_word_t want;
        got = '{res_ch.out_byte, res_ch.end_record, res_ch.byte_count, res_ch.last_of_item};
        result_words++;
        if (got.end_record)
        begin
            end_records++;
        end
        if (pending_words.size() == 0)
        begin
            note_mismatch($sformatf("unexpected word: byte %h end %b count %0d last %b",
                                    got.out_byte, got.end_record, got.byte_count,
                                    got.last_of_item));
        end
        else
        begin
            want = pending_words.pop_front();
            if (got !== want)
            begin
                note_mismatch($sformatf(
                    "byte %h/%h end %b/%b count %0d/%0d last %b/%b (got/expected)",
                    got.out_byte, want.out_byte, got.end_record, want.end_record,
                    got.byte_count, want.byte_count, got.last_of_item, want.last_of_item));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            check_result_word();
        end
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("utf16le_to_utf8_transcoder_tb failed");
        $finish;
    end

    initial
    begin
        int r;
        int p;
        int target;
        rst_n             = 1'b0;
        unit_ch.valid     = 1'b0;
        unit_ch.code_unit = 16'd0;
        unit_ch.last_unit = 1'b0;
        cap_ch.valid      = 1'b0;
        cap_ch.max_bytes  = 16'd0;
        cap_bytes         = u16u8_pkg::MAX_BYTES_RESET;
        held_high         = 16'd0;
        held_valid        = 1'b0;
        byte_total        = 16'd0;
        halted            = 1'b0;
        mismatches        = 0;
        units_sent        = 0;
        result_words      = 0;
        end_records       = 0;
        cap_writes        = 0;
        calm              = 1'b0;
        hold_request      = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (DIRECTED[r].kind == ROW_CAP)
            begin
                write_capacity(DIRECTED[r].value);
            end
            else
            begin
                send_unit(DIRECTED[r].value, DIRECTED[r].fin, int'(DIRECTED[r].n_typed),
                          DIRECTED[r].typed);
            end
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                write_capacity(16'($urandom_range(0, 40)));
                calm = 1'b1;
            end
            else
            begin
                write_capacity(PHASE_CAPS[p]);
            end
            if (p == 2)
            begin
                hold_request = 1'b1;
            end
            target = units_sent + PHASE_UNITS;
            while (units_sent < target)
            begin
                send_random_char();
            end
        end

        wait_drained();
        if (pending_words.size() != 0)
        begin
            note_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
        end
        $display("Sent %0d code units under %0d capacity settings, including zero and full.",
                 units_sent, cap_writes);
        $display("Checked %0d result words, %0d of them end records.", result_words, end_records);
        if (mismatches == 0)
        begin
            $display("utf16le_to_utf8_transcoder_tb passed");
        end
        else
        begin
            $display("utf16le_to_utf8_transcoder_tb failed");
        end
        $finish;
    end

endmodule
